// ===== hw/rtl/popup_headlight_motor_sequencer_macros.svh =====
// Assertion helpers for the headlamp motor sequencer.
`ifndef POPUP_HEADLIGHT_MOTOR_SEQUENCER_MACROS_SVH
`define POPUP_HEADLIGHT_MOTOR_SEQUENCER_MACROS_SVH

`ifndef SYNTHESIS
`define PHMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("phms assertion failed");
`define PHMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("phms assertion failed");
`else
`define PHMS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PHMS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// ===== hw/rtl/phms_pkg.sv =====
package phms_pkg;

    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 1;
    localparam int TIME_W    = 32;
    localparam int PART_W    = CFG_W + 1;

    typedef logic [1:0]          t_mode;
    typedef logic [2:0]          t_goal;
    typedef logic [1:0]          t_pos;
    typedef logic [CFG_W-1:0]    t_cfg_val;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic [TIME_W-1:0]   t_time;

    localparam t_mode MODE_TICK   = 2'd0;
    localparam t_mode MODE_TARGET = 2'd1;
    localparam t_mode MODE_SLEEPY = 2'd2;
    localparam t_mode MODE_WINK   = 2'd3;

    localparam t_goal GOAL_IDLE    = 3'd0;
    localparam t_goal GOAL_UP      = 3'd1;
    localparam t_goal GOAL_DOWN    = 3'd2;
    localparam t_goal GOAL_MID     = 3'd3;
    localparam t_goal GOAL_TIMEOUT = 3'd4;

    localparam t_pos POS_UP   = 2'd0;
    localparam t_pos POS_DOWN = 2'd1;
    localparam t_pos POS_MID  = 2'd2;

    localparam t_cfg_idx CFG_TIMEOUT = 1'd0;
    localparam t_cfg_idx CFG_SLEEPY  = 1'd1;

    localparam t_cfg_val TIMEOUT_RST = 16'd1500;
    localparam t_cfg_val SLEEPY_RST  = 16'd200;

    typedef struct packed {
        t_mode mode;
        t_goal target_code;
        logic  sleepy_enable;
        logic  up_sense;
        logic  down_sense;
        t_time now_ms;
    } t_item;

    typedef struct packed {
        t_cfg_val timeout_ms;
        t_cfg_val sleepy_move_ms;
    } t_cfg;

    typedef struct packed {
        t_goal                   cur;
        t_goal                   prev;
        logic                    running;
        t_time                   start;
        logic                    sleepy;
        logic signed [PART_W-1:0] partial;
    } t_state;

endpackage

// ===== hw/rtl/phms_in_if.sv =====
interface phms_in_if;
    logic              valid;
    logic              ready;
    phms_pkg::t_mode   mode;
    phms_pkg::t_goal   target_code;
    logic              sleepy_enable;
    logic              up_sense;
    logic              down_sense;
    phms_pkg::t_time   now_ms;

    modport source(output valid, mode, target_code, sleepy_enable, up_sense, down_sense,
                   now_ms, input ready);
    modport sink(input valid, mode, target_code, sleepy_enable, up_sense, down_sense,
                 now_ms, output ready);
endinterface

// ===== hw/rtl/phms_out_if.sv =====
interface phms_out_if;
    logic            valid;
    logic            ready;
    logic            motor_on;
    phms_pkg::t_goal target_now;
    phms_pkg::t_goal target_before;
    phms_pkg::t_pos  position;

    modport source(output valid, motor_on, target_now, target_before, position, input ready);
    modport sink(input valid, motor_on, target_now, target_before, position, output ready);
endinterface

// ===== hw/rtl/popup_headlight_motor_sequencer.sv =====
// Pop-up headlamp lift motor sequencer, one motor.
// i_in carries requests (tick, set target, sleepy mode, wink) with the two
// position sensor levels and a millisecond timestamp; o_out carries one result
// per request: motor drive, current and previous target, sensed position.
// Both channels transfer on valid && ready at a rising clock edge.
// i_cfg_we/i_cfg_idx/i_cfg_data write timeout_ms (index 0) and sleepy_move_ms
// (index 1); write only while no request is in flight.
// A transferred request lands in the input register, is evaluated against
// the state when it advances into the output register, and its result shows
// on o_out from then on.
// Throughput: one request per cycle while o_out is not stalled; the state
// update is a single 32-bit subtract and two compares between the input
// register and the state/result registers.
// When the receiver stalls, the result holds in the output register, one more
// request waits in the input register, then i_in.ready drops.
// Reset (synchronous, active low) clears both stages, sets the targets to
// idle, stops the motor and restores the register defaults (1500, 200).
`include "popup_headlight_motor_sequencer_macros.svh"

module popup_headlight_motor_sequencer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  phms_pkg::t_cfg_idx  i_cfg_idx,
    input  phms_pkg::t_cfg_val  i_cfg_data,
    phms_in_if.sink             i_in,
    phms_out_if.source          o_out
);

    logic              w_s1_valid;
    phms_pkg::t_item   w_s1_item;
    logic              w_advance;
    phms_pkg::t_cfg    r_cfg;
    phms_pkg::t_state  r_state;
    phms_pkg::t_state  n_state;
    phms_pkg::t_pos    n_pos;
    logic              r_out_valid;
    logic              r_motor_on;
    phms_pkg::t_goal   r_target_now;
    phms_pkg::t_goal   r_target_before;
    phms_pkg::t_pos    r_position;
    logic              w_out_take;
    logic              w_out_match;
    logic              w_tick_take;

    assign w_advance = w_s1_valid && (!r_out_valid || o_out.ready);

    phms_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_valid   (w_s1_valid),
        .o_item    (w_s1_item)
    );

    phms_step u_step (
        .i_item  (w_s1_item),
        .i_state (r_state),
        .i_cfg   (r_cfg),
        .o_state (n_state),
        .o_pos   (n_pos)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.timeout_ms     <= phms_pkg::TIMEOUT_RST;
            r_cfg.sleepy_move_ms <= phms_pkg::SLEEPY_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                phms_pkg::CFG_TIMEOUT: r_cfg.timeout_ms     <= i_cfg_data;
                phms_pkg::CFG_SLEEPY:  r_cfg.sleepy_move_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.cur     <= phms_pkg::GOAL_IDLE;
            r_state.prev    <= phms_pkg::GOAL_IDLE;
            r_state.running <= 1'b0;
            r_state.start   <= '1;
            r_state.sleepy  <= 1'b0;
            r_state.partial <= '1;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_motor_on      <= n_state.running;
            r_target_now    <= n_state.cur;
            r_target_before <= n_state.prev;
            r_position      <= n_pos;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.motor_on      = r_motor_on;
    assign o_out.target_now    = r_target_now;
    assign o_out.target_before = r_target_before;
    assign o_out.position      = r_position;

    assign w_out_take  = o_out.valid && o_out.ready;
    assign w_out_match = (o_out.target_now == r_state.cur) &&
                         (o_out.target_before == r_state.prev) &&
                         (o_out.motor_on == r_state.running);
    assign w_tick_take = w_advance && (w_s1_item.mode == phms_pkg::MODE_TICK);

    `PHMS_ASSERT_IMP(a_in_room, i_clk, i_rst_n, i_in.valid && i_in.ready, !w_s1_valid || w_advance)
    `PHMS_ASSERT_NXT(a_out_drain, i_clk, i_rst_n, w_out_take && !w_advance, !o_out.valid)
    `PHMS_ASSERT_IMP(a_out_state, i_clk, i_rst_n, o_out.valid, w_out_match)
    `PHMS_ASSERT_IMP(a_run_on_tick, i_clk, i_rst_n, $rose(r_state.running), $past(w_tick_take))

endmodule

// ===== hw/rtl/phms_in_stage.sv =====
module phms_in_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    phms_in_if.sink           i_in,
    input  logic              i_advance,
    output logic              o_valid,
    output phms_pkg::t_item   o_item
);

    logic            r_valid;
    phms_pkg::t_item r_item;
    logic            w_take;

    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_take) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_item.mode          <= i_in.mode;
            r_item.target_code   <= i_in.target_code;
            r_item.sleepy_enable <= i_in.sleepy_enable;
            r_item.up_sense      <= i_in.up_sense;
            r_item.down_sense    <= i_in.down_sense;
            r_item.now_ms        <= i_in.now_ms;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// ===== hw/rtl/phms_step.sv =====
module phms_step (
    input  phms_pkg::t_item  i_item,
    input  phms_pkg::t_state i_state,
    input  phms_pkg::t_cfg   i_cfg,
    output phms_pkg::t_state o_state,
    output phms_pkg::t_pos   o_pos
);

    phms_pkg::t_pos                      w_pos;
    phms_pkg::t_goal                     w_sensed;
    phms_pkg::t_time                     w_base;
    logic signed [phms_pkg::TIME_W-1:0]  w_elapsed;
    logic signed [phms_pkg::TIME_W-1:0]  w_timeout;
    logic signed [phms_pkg::TIME_W-1:0]  w_part_ext;
    logic                                w_over;
    logic                                w_part_done;
    logic signed [phms_pkg::PART_W-1:0]  w_sleepy_part;

    always_comb begin
        if (i_item.up_sense && !i_item.down_sense) begin
            w_pos = phms_pkg::POS_UP;
        end else if (!i_item.up_sense && i_item.down_sense) begin
            w_pos = phms_pkg::POS_DOWN;
        end else begin
            w_pos = phms_pkg::POS_MID;
        end
    end

    always_comb begin
        case (w_pos)
            phms_pkg::POS_UP:   w_sensed = phms_pkg::GOAL_UP;
            phms_pkg::POS_DOWN: w_sensed = phms_pkg::GOAL_DOWN;
            default:            w_sensed = phms_pkg::GOAL_MID;
        endcase
    end

    // a run that starts on this tick has zero elapsed time
    assign w_base        = i_state.running ? i_state.start : i_item.now_ms;
    assign w_elapsed     = $signed(i_item.now_ms - w_base);
    assign w_timeout     = $signed({{(phms_pkg::TIME_W-phms_pkg::CFG_W){1'b0}},
                                    i_cfg.timeout_ms});
    assign w_part_ext    = {{(phms_pkg::TIME_W-phms_pkg::PART_W){i_state.partial[phms_pkg::PART_W-1]}},
                            i_state.partial};
    assign w_over        = w_elapsed > w_timeout;
    assign w_part_done   = w_elapsed >= w_part_ext;
    assign w_sleepy_part = $signed({1'b0, i_cfg.sleepy_move_ms});

    always_comb begin
        o_state = i_state;
        case (i_item.mode)
            phms_pkg::MODE_TICK: begin
                if (i_state.cur != phms_pkg::GOAL_IDLE &&
                    i_state.cur != phms_pkg::GOAL_TIMEOUT) begin
                    if (w_sensed != i_state.cur) begin
                        o_state.running = 1'b1;
                        o_state.start   = w_base;
                        if (w_over) begin
                            o_state.running = 1'b0;
                            o_state.prev    = i_state.cur;
                            o_state.cur     = phms_pkg::GOAL_TIMEOUT;
                        end else if (i_state.cur == phms_pkg::GOAL_MID && w_part_done) begin
                            o_state.running = 1'b0;
                            o_state.prev    = i_state.cur;
                            o_state.cur     = phms_pkg::GOAL_IDLE;
                        end
                    end else if (i_state.cur == phms_pkg::GOAL_UP && i_state.sleepy) begin
                        o_state.partial = w_sleepy_part;
                        o_state.cur     = phms_pkg::GOAL_MID;
                    end else begin
                        o_state.running = 1'b0;
                        o_state.prev    = i_state.cur;
                        o_state.cur     = phms_pkg::GOAL_IDLE;
                    end
                end
            end
            phms_pkg::MODE_TARGET: begin
                if (i_item.target_code inside {[phms_pkg::GOAL_IDLE:phms_pkg::GOAL_TIMEOUT]} &&
                    i_state.cur != phms_pkg::GOAL_TIMEOUT) begin
                    if (i_item.target_code == phms_pkg::GOAL_MID &&
                        w_sensed == phms_pkg::GOAL_MID) begin
                        o_state.prev = phms_pkg::GOAL_MID;
                        o_state.cur  = phms_pkg::GOAL_IDLE;
                    end else begin
                        o_state.cur = i_item.target_code;
                    end
                end
            end
            phms_pkg::MODE_SLEEPY: begin
                o_state.sleepy = i_item.sleepy_enable;
                if (i_item.sleepy_enable) begin
                    if (w_sensed != phms_pkg::GOAL_UP) begin
                        o_state.cur = phms_pkg::GOAL_UP;
                    end else begin
                        o_state.partial = w_sleepy_part;
                        if (i_state.cur != phms_pkg::GOAL_TIMEOUT) begin
                            o_state.cur = phms_pkg::GOAL_MID;
                        end
                    end
                end
            end
            phms_pkg::MODE_WINK: begin
                if (i_state.cur == phms_pkg::GOAL_IDLE) begin
                    o_state.cur = (i_state.prev == phms_pkg::GOAL_DOWN) ?
                                  phms_pkg::GOAL_UP : phms_pkg::GOAL_DOWN;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pos = w_pos;

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

    localparam int              QUIET_LIMIT = 3000;
    localparam int              PHASE_ITEMS = 316;
    localparam phms_pkg::t_goal GOAL_UNUSED = 3'd7;

    typedef struct packed {
        logic            motor_on;
        phms_pkg::t_goal target_now;
        phms_pkg::t_goal target_before;
        phms_pkg::t_pos  position;
    } t_lamp_status;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    phms_pkg::t_cfg_idx cfg_idx;
    phms_pkg::t_cfg_val cfg_data;

    phms_in_if  in_if();
    phms_out_if out_if();

    popup_headlight_motor_sequencer uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_if),
        .o_out      (out_if)
    );

    // lamp model state
    phms_pkg::t_goal    goal_now   = phms_pkg::GOAL_IDLE;
    phms_pkg::t_goal    goal_prev  = phms_pkg::GOAL_IDLE;
    logic               motor_run  = 1'b0;
    phms_pkg::t_time    run_start  = '1;
    logic               sleepy_on  = 1'b0;
    logic signed [16:0] partial_ms = -17'sd1;
    phms_pkg::t_cfg_val timeout_cfg;
    phms_pkg::t_cfg_val sleepy_cfg;

    phms_pkg::t_item request_q[$];
    t_lamp_status    lamp_status_q[$];

    phms_pkg::t_item held_item = '0;
    bit    offering = 1'b0;
    int    gap_left;
    bit    calm_in = 1'b0;
    int    stall_left;
    int    hold_left;
    bit    calm_out = 1'b0;
    int    quiet_cycles = 0;

    int n_sent = 0;
    int n_checked = 0;
    int n_mismatch = 0;
    int n_settings;
    int n_arrivals = 0;
    int n_partials = 0;
    int n_timeouts = 0;
    phms_pkg::t_time clock_ms;

    always #5 i_clk = ~i_clk;

    function automatic void halt_motor(input bit by_timeout);
        motor_run = 1'b0;
        goal_prev = goal_now;
        goal_now  = by_timeout ? phms_pkg::GOAL_TIMEOUT : phms_pkg::GOAL_IDLE;
    endfunction

    function automatic void request_goal(input phms_pkg::t_goal goal,
                                         input phms_pkg::t_goal seen);
        if (goal_now == phms_pkg::GOAL_TIMEOUT) return;
        goal_now = goal;
        if (goal != phms_pkg::GOAL_UP && goal != phms_pkg::GOAL_DOWN && seen == goal) begin
            goal_prev = goal;
            goal_now  = phms_pkg::GOAL_IDLE;
        end
    endfunction

    function automatic void advance_motor(input phms_pkg::t_time now,
                                          input phms_pkg::t_goal seen);
        phms_pkg::t_time diff;
        longint          elapsed;
        if (goal_now == phms_pkg::GOAL_IDLE || goal_now == phms_pkg::GOAL_TIMEOUT) return;
        if (seen != goal_now) begin
            if (!motor_run) begin
                motor_run = 1'b1;
                run_start = now;
            end
            diff    = now - run_start;
            elapsed = longint'($signed(diff));
            if (elapsed > longint'(timeout_cfg)) begin
                halt_motor(1'b1);
                n_timeouts++;
            end
            if (goal_now == phms_pkg::GOAL_MID && elapsed >= longint'(partial_ms)) begin
                halt_motor(1'b0);
                n_partials++;
            end
        end
        if (seen == goal_now) begin
            if (goal_now == phms_pkg::GOAL_UP && sleepy_on) begin
                partial_ms = $signed({1'b0, sleepy_cfg});
                goal_now   = phms_pkg::GOAL_MID;
                return;
            end
            halt_motor(1'b0);
            n_arrivals++;
        end
    endfunction

    function automatic void predict_lamp(input phms_pkg::t_item it);
        phms_pkg::t_pos  pos;
        phms_pkg::t_goal seen;
        t_lamp_status    st;
        if (it.up_sense && !it.down_sense) pos = phms_pkg::POS_UP;
        else if (!it.up_sense && it.down_sense) pos = phms_pkg::POS_DOWN;
        else pos = phms_pkg::POS_MID;
        seen = (pos == phms_pkg::POS_UP) ? phms_pkg::GOAL_UP :
               (pos == phms_pkg::POS_DOWN) ? phms_pkg::GOAL_DOWN : phms_pkg::GOAL_MID;
        case (it.mode)
            phms_pkg::MODE_TICK: advance_motor(it.now_ms, seen);
            phms_pkg::MODE_TARGET: begin
                if (it.target_code <= phms_pkg::GOAL_TIMEOUT) request_goal(it.target_code, seen);
            end
            phms_pkg::MODE_SLEEPY: begin
                sleepy_on = it.sleepy_enable;
                if (it.sleepy_enable) begin
                    if (seen != phms_pkg::GOAL_UP) begin
                        goal_now = phms_pkg::GOAL_UP;
                    end else begin
                        partial_ms = $signed({1'b0, sleepy_cfg});
                        request_goal(phms_pkg::GOAL_MID, seen);
                    end
                end
            end
            default: begin
                if (goal_now == phms_pkg::GOAL_IDLE)
                    request_goal((goal_prev == phms_pkg::GOAL_DOWN) ?
                                 phms_pkg::GOAL_UP : phms_pkg::GOAL_DOWN, seen);
            end
        endcase
        st.motor_on      = motor_run;
        st.target_now    = goal_now;
        st.target_before = goal_prev;
        st.position      = pos;
        lamp_status_q.push_back(st);
    endfunction

    function automatic phms_pkg::t_item lamp_req(input phms_pkg::t_mode m,
                                                 input phms_pkg::t_goal code,
                                                 input logic en, input logic up,
                                                 input logic dn, input phms_pkg::t_time now);
        phms_pkg::t_item it;
        it.mode          = m;
        it.target_code   = code;
        it.sleepy_enable = en;
        it.up_sense      = up;
        it.down_sense    = dn;
        it.now_ms        = now;
        return it;
    endfunction

    // sensors follow a sticky random walk, time mostly moves forward
    task automatic queue_random(input int count, input int step_max);
        phms_pkg::t_item it;
        logic            up;
        logic            dn;
        int              r;
        up = 1'($urandom_range(0, 1));
        dn = 1'($urandom_range(0, 1));
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 3) == 0) begin
                up = 1'($urandom_range(0, 1));
                dn = 1'($urandom_range(0, 1));
            end
            r = $urandom_range(0, 99);
            if (r < 6) clock_ms = $urandom;
            else if (r < 9) clock_ms = clock_ms - $urandom_range(0, 500);
            else clock_ms = clock_ms + $urandom_range(0, step_max);
            it = lamp_req(phms_pkg::MODE_TICK, phms_pkg::t_goal'($urandom_range(0, 7)),
                          1'($urandom_range(0, 1)), up, dn, clock_ms);
            r = $urandom_range(0, 99);
            if (r < 55) it.mode = phms_pkg::MODE_TICK;
            else if (r < 75) it.mode = phms_pkg::MODE_TARGET;
            else if (r < 88) it.mode = phms_pkg::MODE_SLEEPY;
            else it.mode = phms_pkg::MODE_WINK;
            request_q.push_back(it);
        end
    endtask

    task automatic wait_idle();
        while (request_q.size() != 0 || offering || lamp_status_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_registers(input phms_pkg::t_cfg_val tmo, input phms_pkg::t_cfg_val slp);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= phms_pkg::CFG_TIMEOUT;
        cfg_data <= tmo;
        @(posedge i_clk);
        cfg_idx  <= phms_pkg::CFG_SLEEPY;
        cfg_data <= slp;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        timeout_cfg = tmo;
        sleepy_cfg  = slp;
        n_settings++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
            offering = 1'b0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_lamp(held_item);
                n_sent++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (request_q.size() != 0) begin
                    held_item = request_q.pop_front();
                    offering  = 1'b1;
                    if ($urandom_range(0, 39) == 0) calm_in = !calm_in;
                    gap_left = calm_in ? 0 : $urandom_range(0, 10);
                end
            end
            in_if.valid         <= offering;
            in_if.mode          <= held_item.mode;
            in_if.target_code   <= held_item.target_code;
            in_if.sleepy_enable <= held_item.sleepy_enable;
            in_if.up_sense      <= held_item.up_sense;
            in_if.down_sense    <= held_item.down_sense;
            in_if.now_ms        <= held_item.now_ms;
        end
    end

    // result monitor and checker
    always @(posedge i_clk) begin
        t_lamp_status want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            stall_left = 0;
            hold_left  = 0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (lamp_status_q.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("result transfer with nothing outstanding at %0t", $realtime);
                end else begin
                    want = lamp_status_q.pop_front();
                    if (out_if.motor_on !== want.motor_on
                        || out_if.target_now !== want.target_now
                        || out_if.target_before !== want.target_before
                        || out_if.position !== want.position) begin
                        n_mismatch++;
                        if (n_mismatch <= 10)
                            $display({"mismatch at %0t: motor %0b/%0b target %0d/%0d ",
                                      "before %0d/%0d pos %0d/%0d (exp/got)"},
                                     $realtime, want.motor_on, out_if.motor_on,
                                     want.target_now, out_if.target_now,
                                     want.target_before, out_if.target_before,
                                     want.position, out_if.position);
                    end
                end
                n_checked++;
                if (n_checked % 700 == 350) hold_left = 150 + $urandom_range(0, 100);
                if ($urandom_range(0, 39) == 0) calm_out = !calm_out;
                stall_left = calm_out ? 0 : $urandom_range(0, 10);
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("TB_ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        phms_pkg::t_cfg_val tmo_set[6];
        phms_pkg::t_cfg_val slp_set[6];
        tmo_set = '{16'd0, 16'd65535, 16'd300, 16'd1500, 16'd40, 16'd900};
        slp_set = '{16'd0, 16'd65535, 16'd120, 16'd200, 16'd400, 16'd30};

        i_clk    = 1'b0;
        i_rst_n  = 1'b0;
        cfg_we   = 1'b0;
        cfg_idx  = phms_pkg::CFG_TIMEOUT;
        cfg_data = '0;
        n_settings = 0;

        timeout_cfg = phms_pkg::TIMEOUT_RST;
        sleepy_cfg  = phms_pkg::SLEEPY_RST;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset register values
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, GOAL_UNUSED,            1, 1, 1, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_MID,     0, 0, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_WINK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd100));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_UP,      0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_DOWN,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 1, 32'd300));
        request_q.push_back(lamp_req(phms_pkg::MODE_WINK,   phms_pkg::GOAL_IDLE,    0, 0, 1, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 1, 32'd400));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 1, 32'd2000));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_UP,      0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_WINK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_SLEEPY, phms_pkg::GOAL_IDLE,    1, 0, 1, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 1, 32'd3000));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd3100));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd3350));
        request_q.push_back(lamp_req(phms_pkg::MODE_SLEEPY, phms_pkg::GOAL_IDLE,    1, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd3400));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 0, 32'd3500));
        request_q.push_back(lamp_req(phms_pkg::MODE_SLEEPY, phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_TIMEOUT, 0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TARGET, phms_pkg::GOAL_IDLE,    0, 1, 0, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_SLEEPY, phms_pkg::GOAL_IDLE,    1, 0, 1, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_SLEEPY, phms_pkg::GOAL_IDLE,    0, 0, 1, 32'd0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 1,
                                     32'hFFFF_FFF0));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 0,
                                     32'h0000_0010));
        request_q.push_back(lamp_req(phms_pkg::MODE_TICK,   phms_pkg::GOAL_IDLE,    0, 0, 0,
                                     32'h8000_0100));

        clock_ms = $urandom;
        foreach (tmo_set[p]) begin
            wait_idle();
            set_registers(tmo_set[p], slp_set[p]);
            queue_random(PHASE_ITEMS, (tmo_set[p] >> 2) + 20);
        end
        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("%0d requests sent over %0d register settings, %0d results checked",
                 n_sent, n_settings + 1, n_checked);
        $display("motor stops: %0d on arrival, %0d partial move, %0d timeout",
                 n_arrivals, n_partials, n_timeouts);
        if (n_mismatch == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
